// ----- hw/rtl/srtf_pkg.sv -----
// ----------------------------------------------------------------------------
// srtf_pkg
// shared types and constants of the shortest-remaining-time-first scheduler
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int IN_W   = 16;
  localparam int NOW_W  = 21;
  localparam int WAIT_W = 25;
  localparam int ID_W   = 5;

  localparam logic [NOW_W-1:0]  NOW_MAX  = {NOW_W{1'b1}};
  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  // request modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IN_W-1:0] arrival;
    logic [IN_W-1:0] burst;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [NOW_W-1:0]  time_now;
    logic [ID_W-1:0]   process_id;
    logic              completed;
    logic              all_done;
    logic [WAIT_W-1:0] waiting_sum;
    logic [ID_W-1:0]   loaded_count;
  } rsp_t;

  // scan control toward the selection unit
  typedef struct packed {
    logic start;
    logic sample;
  } pick_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_PUT
  } state_t;

endpackage

// ----- hw/rtl/srtf_if.sv -----
// ----------------------------------------------------------------------------
// srtf_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface srtf_req_if;
  import srtf_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srtf_rsp_if;
  import srtf_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/srtf_table_mem.sv -----
// ----------------------------------------------------------------------------
// srtf_table_mem
// process table ram, one write and one registered read port
// ----------------------------------------------------------------------------
module srtf_table_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/srtf_pick.sv -----
// ----------------------------------------------------------------------------
// srtf_pick
// running best-candidate selection over the streamed table entries
// ----------------------------------------------------------------------------
module srtf_pick #(
  parameter int TW = 16,
  parameter int IW = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  srtf_pkg::pick_ctrl_t         ctrl,
  input  logic [srtf_pkg::NOW_W-1:0]   now,
  input  logic [IW-1:0]                samp_idx,
  input  logic [TW-1:0]                samp_arr,
  input  logic [TW-1:0]                samp_bur,
  input  logic [TW-1:0]                samp_rem,
  output logic                         found,
  output logic [IW-1:0]                best_idx,
  output logic [TW-1:0]                best_arr,
  output logic [TW-1:0]                best_bur,
  output logic [TW-1:0]                best_rem
);
  import srtf_pkg::*;

  logic eligible;
  logic better;

  // arrived and unfinished
  assign eligible = (samp_rem != '0) && (NOW_W'(samp_arr) <= now);
  // strict compare keeps the lower load order on a full tie
  assign better = !found || (samp_rem < best_rem) ||
                  ((samp_rem == best_rem) && (samp_arr < best_arr));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.start) begin
      found <= 1'b0;
    end else if (ctrl.sample && eligible && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sample && eligible && better) begin
      best_idx <= samp_idx;
      best_arr <= samp_arr;
      best_bur <= samp_bur;
      best_rem <= samp_rem;
    end
  end

endmodule

// ----- hw/rtl/srtf_preemptive_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler_core
// preemptive shortest-remaining-time-first scheduler with a ram process table
// ----------------------------------------------------------------------------
// sequencing: clear, load, refused or unused requests go from acceptance
//   through the put state into the response register; a carried-out tick
//   first scans the table, reading one entry a cycle through the single ram
//   read port, then passes a drain state for the ram read latency and a
//   write-back state before the put state
// requests: one at a time, the next one taken once the response is loaded,
//   which the put state holds off while the output register is full and not
//   taken; a new request is taken while the last response still waits in
//   the output register
// reset: counters, time, waiting total and run flag clear at once; no request
//   is taken while reset is held; the table ram is not cleared and only
//   entries below loaded_count are ever read
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler_core #(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_BITS     = 16
) (
  input  logic    clk,
  input  logic    rst,
  srtf_req_if.sink   req,
  srtf_rsp_if.source rsp
);
  import srtf_pkg::*;

  // stored time width: arrival and burst keep their low TIME_BITS bits
  localparam int TW = (TIME_BITS < IN_W) ? TIME_BITS : IN_W;
  // table index and process count widths
  localparam int IW = $clog2(MAX_PROCESSES);
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  // one ram word holds arrival, burst and remaining time
  localparam int EW = 3 * TW;

  state_t state, state_next;

  logic [CW-1:0]     process_count;
  logic [CW-1:0]     finished_count;
  logic [NOW_W-1:0]  cur_time;
  logic [WAIT_W-1:0] total_wait;
  logic              run_started;

  logic [IW-1:0]     scan_idx;
  logic              samp;
  logic [IW-1:0]     samp_idx;

  // per-request result fields, captured until the response is built
  logic              res_acc;
  logic [ID_W-1:0]   res_pid;
  logic              res_done;

  logic              out_valid;
  rsp_t              out_data;

  // handshake and decode
  logic req_fire;
  logic is_clear, is_load, is_tick;
  logic load_ok, tick_ok;
  logic scan_last;
  logic put_go;

  // datapath
  logic [TW-1:0]     arr_in, bur_in;
  logic [EW-1:0]     rd_data;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic              rd_en;
  logic              upd;
  logic              put;
  pick_ctrl_t        pick_ctrl;

  logic              found;
  logic [IW-1:0]     best_idx;
  logic [TW-1:0]     best_arr, best_bur, best_rem;

  logic [TW-1:0]     rem_dec;
  logic              finish_now;
  logic [NOW_W-1:0]  time_inc;
  logic [TW:0]       base;
  logic [NOW_W-1:0]  base_ext;
  logic [NOW_W-1:0]  wait_add;
  logic [WAIT_W:0]   wait_sum;
  logic [WAIT_W-1:0] wait_sat;
  logic [31:0]       pid_full;
  logic [31:0]       cnt_full;
  logic [CW-1:0]     last_cnt;

  assign req_fire = req.valid && req.ready;
  assign arr_in   = req.data.arrival[TW-1:0];
  assign bur_in   = req.data.burst[TW-1:0];

  // mode decode
  always_comb begin
    is_clear = 1'b0;
    is_load  = 1'b0;
    is_tick  = 1'b0;
    unique case (req.data.mode)
      MODE_CLEAR: is_clear = 1'b1;
      MODE_LOAD:  is_load  = 1'b1;
      MODE_TICK:  is_tick  = 1'b1;
      default: ;
    endcase
  end

  // load refused when full, zero burst, or the run has begun
  assign load_ok = (process_count != CW'(MAX_PROCESSES)) && (bur_in != '0) && !run_started;
  // tick refused once every loaded process is done
  assign tick_ok = (finished_count != process_count);

  assign last_cnt  = process_count - CW'(1);
  assign scan_last = (CW'(scan_idx) == last_cnt);
  assign put_go    = !out_valid || rsp.ready;

  // write-back arithmetic for the chosen entry
  assign rem_dec    = best_rem - TW'(1);
  assign finish_now = found && (rem_dec == '0);
  assign time_inc   = (cur_time != NOW_MAX) ? cur_time + NOW_W'(1) : cur_time;
  assign base       = {1'b0, best_arr} + {1'b0, best_bur};
  assign base_ext   = NOW_W'(base);
  // waiting time never goes negative
  assign wait_add   = (time_inc > base_ext) ? time_inc - base_ext : '0;
  assign wait_sum   = {1'b0, total_wait} + (WAIT_W + 1)'(wait_add);
  assign wait_sat   = wait_sum[WAIT_W] ? WAIT_MAX : wait_sum[WAIT_W-1:0];
  // id is load order plus one, masked to the field width
  assign pid_full   = 32'(best_idx) + 32'd1;
  assign cnt_full   = 32'(process_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (is_tick && tick_ok) ? S_SCAN : S_PUT;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_UPDATE;
      S_UPDATE: state_next = S_PUT;
      S_PUT: begin
        if (put_go) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready        = 1'b0;
    rd_en            = 1'b0;
    upd              = 1'b0;
    put              = 1'b0;
    unique case (state)
      S_IDLE:   req.ready = !rst;
      S_SCAN:   rd_en     = 1'b1;
      S_DRAIN:  ;
      S_UPDATE: upd       = 1'b1;
      S_PUT:    put       = put_go;
      default:  ;
    endcase
  end

  assign pick_ctrl.start  = req_fire;
  assign pick_ctrl.sample = samp;

  // ram write: append on load, remaining time write-back after a scan
  always_comb begin
    if (upd) begin
      wr_en   = found;
      wr_addr = best_idx;
      wr_data = {best_arr, best_bur, rem_dec};
    end else begin
      wr_en   = req_fire && is_load && load_ok;
      wr_addr = process_count[IW-1:0];
      wr_data = {arr_in, bur_in, bur_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scheduler state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= '0;
      finished_count <= '0;
      cur_time       <= '0;
      total_wait     <= '0;
      run_started    <= 1'b0;
      samp           <= 1'b0;
    end else begin
      samp <= rd_en;
      if (req_fire) begin
        if (is_clear) begin
          process_count  <= '0;
          finished_count <= '0;
          cur_time       <= '0;
          total_wait     <= '0;
          run_started    <= 1'b0;
        end
        if (is_load && load_ok) begin
          process_count <= process_count + CW'(1);
        end
        if (is_tick && tick_ok) begin
          run_started <= 1'b1;
        end
      end
      if (upd) begin
        cur_time <= time_inc;
        if (finish_now) begin
          total_wait     <= wait_sat;
          finished_count <= finished_count + CW'(1);
        end
      end
    end
  end

  // scan address, sample index and per-request result fields
  always_ff @(posedge clk) begin
    samp_idx <= scan_idx;
    if (req_fire) begin
      scan_idx <= '0;
      res_acc  <= is_clear || (is_load && load_ok) || (is_tick && tick_ok);
      res_pid  <= '0;
      res_done <= 1'b0;
    end else if (rd_en) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (upd && found) begin
      res_pid  <= pid_full[ID_W-1:0];
      res_done <= finish_now;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_data.accepted     <= res_acc;
      out_data.time_now     <= cur_time;
      out_data.process_id   <= res_pid;
      out_data.completed    <= res_done;
      out_data.all_done     <= (finished_count == process_count);
      out_data.waiting_sum  <= total_wait;
      out_data.loaded_count <= cnt_full[ID_W-1:0];
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  srtf_table_mem #(
    .DEPTH (MAX_PROCESSES),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  srtf_pick #(
    .TW (TW),
    .IW (IW)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (pick_ctrl),
    .now      (cur_time),
    .samp_idx (samp_idx),
    .samp_arr (rd_data[3*TW-1:2*TW]),
    .samp_bur (rd_data[2*TW-1:TW]),
    .samp_rem (rd_data[TW-1:0]),
    .found    (found),
    .best_idx (best_idx),
    .best_arr (best_arr),
    .best_bur (best_bur),
    .best_rem (best_rem)
  );

  // finished processes never outnumber loaded ones
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    finished_count <= process_count)
    else $error("finished count exceeds process count");

  // the scan runs until the last loaded entry has been read
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !scan_last) |=> (state == S_SCAN))
    else $error("scan ended early");

  // an accepted request goes to the scan or straight to the response
  a_req_path: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == S_SCAN || state == S_PUT))
    else $error("unexpected state after request");

  // no table write while the scan reads the table
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE || state == S_UPDATE))
    else $error("table write during scan");

  // a write-back always follows a completed drain of the scan
  a_drain_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_UPDATE && $past(samp)))
    else $error("drain not followed by update");

endmodule

// ----- tb/srtf_preemptive_scheduler_core_tb.sv -----
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler_core_tb
// drives clear, load, tick and unused requests into the scheduler core over the
// request channel and checks every response against a fixed value or a cycle-free
// model of the process table, with random idling on both channels, a calm stretch
// and one long response hold-off that backs the core up into its request side
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler_core_tb;
  import srtf_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int TOTAL_ITEMS   = 1150;   // directed plus random requests
  localparam int IDLE_PCT      = 28;
  localparam int CALM_FROM     = 350;    // request count window with no idling
  localparam int CALM_TO       = 600;
  localparam int HOLD_AT       = 800;    // response count that starts the hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;   // cycles without any handshake
  localparam int DRAIN_CYCLES  = 40;

  // mode 3 has no function in the core
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // response of an item that changed nothing on an empty table
  localparam rsp_t IDLE_EMPTY = '{1'b0, 21'd0, 5'd0, 1'b0, 1'b1, 25'd0, 5'd0};
  // response of a carried-out clear
  localparam rsp_t CLEARED    = '{1'b1, 21'd0, 5'd0, 1'b0, 1'b1, 25'd0, 5'd0};
  localparam rsp_t NO_WANT    = '0;

  typedef struct packed {
    req_t stim;
    logic typed;   // 1: want is the expected response, 0: ask the model
    rsp_t want;
  } dir_row_t;

  localparam int DIR_N = 25;

  // directed requests: reset corner, refusals, tie breaks, idle ticks,
  // a tick after the run and loads after the run has begun
  localparam dir_row_t DIRECTED_ROWS [DIR_N] = '{
    // tick on an empty table is refused
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b1, IDLE_EMPTY},
    // unused mode changes nothing
    '{'{MODE_UNUSED, 16'hFFFF, 16'hFFFF}, 1'b1, IDLE_EMPTY},
    // zero burst is refused
    '{'{MODE_LOAD,   16'h0005, 16'h0000}, 1'b1, IDLE_EMPTY},
    '{'{MODE_LOAD,   16'h0000, 16'h0001}, 1'b1,
      '{1'b1, 21'd0, 5'd0, 1'b0, 1'b0, 25'd0, 5'd1}},
    // largest arrival and burst, never arrives in this run
    '{'{MODE_LOAD,   16'hFFFF, 16'hFFFF}, 1'b1,
      '{1'b1, 21'd0, 5'd0, 1'b0, 1'b0, 25'd0, 5'd2}},
    // same arrival and burst as the first one: lower load order wins
    '{'{MODE_LOAD,   16'h0000, 16'h0001}, 1'b0, NO_WANT},
    '{'{MODE_LOAD,   16'h0000, 16'h0002}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h1234, 16'h4321}, 1'b0, NO_WANT},
    // load once ticks have run is refused
    '{'{MODE_LOAD,   16'h0000, 16'h0003}, 1'b0, NO_WANT},
    '{'{MODE_UNUSED, 16'hA5A5, 16'h5A5A}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    // only the late process is left: idle tick
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    '{'{MODE_CLEAR,  16'h1234, 16'hFFFF}, 1'b1, CLEARED},
    '{'{MODE_LOAD,   16'h0002, 16'h0002}, 1'b0, NO_WANT},
    '{'{MODE_LOAD,   16'h0002, 16'h0001}, 1'b0, NO_WANT},
    // two idle ticks before the arrivals, then the shorter one first
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    '{'{MODE_TICK,   16'h0000, 16'h0000}, 1'b0, NO_WANT},
    // everything finished: tick is refused
    '{'{MODE_TICK,   16'hFFFF, 16'hFFFF}, 1'b0, NO_WANT},
    '{'{MODE_LOAD,   16'h0000, 16'h0004}, 1'b0, NO_WANT},
    '{'{MODE_CLEAR,  16'h0000, 16'h0000}, 1'b1, CLEARED}
  };

  logic clk;
  logic rst;
  logic calm;          // no idling on either side while set
  int   req_count;     // accepted requests other than unused mode
  int   mismatches;

  srtf_req_if req_bus ();
  srtf_rsp_if rsp_bus ();

  srtf_preemptive_scheduler_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // model of the process table and run counters
  logic [IN_W-1:0]   proc_arrival [TABLE_DEPTH];
  logic [IN_W-1:0]   proc_burst   [TABLE_DEPTH];
  logic [IN_W-1:0]   proc_left    [TABLE_DEPTH];
  int                proc_count;
  int                done_count;
  logic [NOW_W-1:0]  sched_now;
  logic [WAIT_W-1:0] wait_total;
  logic              run_begun;

  // responses still owed by the core, oldest first
  rsp_t pending_rsps [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request through the model: updates the table, returns the response
  function automatic rsp_t schedule_step(input req_t r);
    rsp_t   o;
    int     best;
    longint base;
    longint gap;
    longint sum;
    o = '0;
    case (r.mode)
      MODE_CLEAR: begin
        proc_count = 0;
        done_count = 0;
        sched_now  = '0;
        wait_total = '0;
        run_begun  = 1'b0;
        o.accepted = 1'b1;
      end
      MODE_LOAD: begin
        if (proc_count < TABLE_DEPTH && r.burst != '0 && !run_begun) begin
          proc_arrival[proc_count] = r.arrival;
          proc_burst[proc_count]   = r.burst;
          proc_left[proc_count]    = r.burst;
          proc_count++;
          o.accepted = 1'b1;
        end
      end
      MODE_TICK: begin
        if (done_count < proc_count) begin
          // least remaining time among arrived, unfinished; ties to earlier
          // arrival, then to lower load order
          best = -1;
          for (int k = 0; k < proc_count; k++) begin
            if (proc_left[k] != '0 && proc_arrival[k] <= sched_now) begin
              if (best < 0 || proc_left[k] < proc_left[best] ||
                  (proc_left[k] == proc_left[best] &&
                   proc_arrival[k] < proc_arrival[best]))
                best = k;
            end
          end
          o.accepted = 1'b1;
          run_begun  = 1'b1;
          if (sched_now != NOW_MAX) sched_now = sched_now + 1'b1;
          if (best >= 0) begin
            o.process_id   = ID_W'(best + 1);
            proc_left[best] = proc_left[best] - 1'b1;
            if (proc_left[best] == '0) begin
              base = longint'(proc_arrival[best]) + longint'(proc_burst[best]);
              gap  = (longint'(sched_now) > base) ? longint'(sched_now) - base : 0;
              sum  = longint'(wait_total) + gap;
              wait_total  = (sum > longint'(WAIT_MAX)) ? WAIT_MAX : sum[WAIT_W-1:0];
              done_count++;
              o.completed = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    o.time_now     = sched_now;
    o.all_done     = (done_count == proc_count);
    o.waiting_sum  = wait_total;
    o.loaded_count = ID_W'(proc_count);
    return o;
  endfunction

  function automatic req_t noise_req(input logic [1:0] m);
    req_t q;
    q.mode    = m;
    q.arrival = IN_W'($urandom);
    q.burst   = IN_W'($urandom);
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("srtf tb mismatch: %s", msg);
    mismatches++;
  endtask

  // offer one request, with a random gap in front unless calm, and file the
  // expected response once the core takes it
  task automatic send_req(input req_t r, input logic typed, input rsp_t want);
    rsp_t guess;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= r;
    do @(posedge clk); while (!req_bus.ready);
    guess = schedule_step(r);
    pending_rsps.push_back(typed ? want : guess);
    if (r.mode != MODE_UNUSED) req_count++;
    calm <= (req_count >= CALM_FROM && req_count < CALM_TO);
  endtask

  // request side: reset, directed table, then random runs
  initial begin : request_source
    req_t r;
    int   pick;
    int   n;
    int   full;
    int   needed;
    int   max_arr;
    int   sum_bur;
    int   tick_n;
    req_bus.valid <= 1'b0;
    req_bus.data  <= '0;
    rst           <= 1'b1;
    calm          <= 1'b0;
    req_count  = 0;
    mismatches = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    proc_count = 0;
    done_count = 0;
    sched_now  = '0;
    wait_total = '0;
    run_begun  = 1'b0;

    for (int i = 0; i < DIR_N; i++)
      send_req(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    // each pass is one run: mostly a clear, a batch of loads, then enough
    // ticks to finish it plus a few refused ones; some runs stop early and
    // some carry noise (unused mode, late loads, a clear mid-run)
    while (req_count < TOTAL_ITEMS) begin
      if ($urandom_range(99) < 90) send_req(noise_req(MODE_CLEAR), 1'b0, NO_WANT);

      full    = ($urandom_range(99) < 12);
      n       = full ? TABLE_DEPTH + $urandom_range(2) : $urandom_range(6, 1);
      max_arr = 0;
      sum_bur = 0;
      for (int i = 0; i < n; i++) begin
        r.mode = MODE_LOAD;
        pick   = $urandom_range(99);
        if (full) begin
          r.arrival = IN_W'($urandom_range(6));
          r.burst   = IN_W'($urandom_range(3, 1));
        end else if (pick < 7) begin
          r.arrival = IN_W'($urandom);
          r.burst   = '0;
        end else if (pick < 12) begin
          // full-width values, the run is cut short by the tick cap
          r.arrival = IN_W'($urandom);
          r.burst   = IN_W'($urandom);
        end else begin
          r.arrival = IN_W'($urandom_range(15));
          r.burst   = IN_W'($urandom_range(8, 1));
        end
        if (r.burst != '0) begin
          if (int'(r.arrival) > max_arr) max_arr = int'(r.arrival);
          sum_bur += int'(r.burst);
        end
        send_req(r, 1'b0, NO_WANT);
        if ($urandom_range(99) < 4) send_req(noise_req(MODE_UNUSED), 1'b0, NO_WANT);
      end

      needed = max_arr + sum_bur;
      if (needed > 150) needed = 150;
      tick_n = ($urandom_range(99) < 80) ? needed + $urandom_range(3, 1)
                                         : $urandom_range(needed);
      for (int j = 0; j < tick_n; j++) begin
        pick = $urandom_range(99);
        if (pick < 3)      send_req(noise_req(MODE_LOAD), 1'b0, NO_WANT);
        else if (pick < 6) send_req(noise_req(MODE_UNUSED), 1'b0, NO_WANT);
        else if (pick < 7) send_req(noise_req(MODE_CLEAR), 1'b0, NO_WANT);
        else               send_req(noise_req(MODE_TICK), 1'b0, NO_WANT);
      end
    end
    req_bus.valid <= 1'b0;

    // drain: every response in, then a little slack for strays
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("srtf_preemptive_scheduler_core_tb: done, clean");
    else
      $display("srtf_preemptive_scheduler_core_tb: done, errors");
    $finish;
  end

  // response side: random ready, one long hold-off, field-by-field compare
  initial begin : response_sink
    rsp_t want;
    rsp_t got;
    int   seen;
    int   hold_left;
    logic held;
    seen      = 0;
    hold_left = 0;
    held      = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        got = rsp_bus.data;
        if (pending_rsps.size() == 0) begin
          report_mismatch($sformatf("response %0d with none pending", seen));
        end else begin
          want = pending_rsps.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch($sformatf("rsp %0d accepted %0d want %0d",
                                      seen, got.accepted, want.accepted));
          if (got.time_now !== want.time_now)
            report_mismatch($sformatf("rsp %0d time_now %0d want %0d",
                                      seen, got.time_now, want.time_now));
          if (got.process_id !== want.process_id)
            report_mismatch($sformatf("rsp %0d process_id %0d want %0d",
                                      seen, got.process_id, want.process_id));
          if (got.completed !== want.completed)
            report_mismatch($sformatf("rsp %0d completed %0d want %0d",
                                      seen, got.completed, want.completed));
          if (got.all_done !== want.all_done)
            report_mismatch($sformatf("rsp %0d all_done %0d want %0d",
                                      seen, got.all_done, want.all_done));
          if (got.waiting_sum !== want.waiting_sum)
            report_mismatch($sformatf("rsp %0d waiting_sum %0d want %0d",
                                      seen, got.waiting_sum, want.waiting_sum));
          if (got.loaded_count !== want.loaded_count)
            report_mismatch($sformatf("rsp %0d loaded_count %0d want %0d",
                                      seen, got.loaded_count, want.loaded_count));
        end
        seen++;
      end
      // long hold-off so the output register fills and request ready drops
      if (seen == HOLD_AT && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ends a run that stops moving on both channels
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("srtf_preemptive_scheduler_core_tb: done, errors");
    $finish;
  end

endmodule
